FILE: rtl/core/iq_fullscale_packet_framer_top_assert.svh
// ----------------------------------------------------------------------------
// iq_fullscale_packet_framer_top_assert.svh
// Assertion macros for the packet framer; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef IQ_FULLSCALE_PACKET_FRAMER_TOP_ASSERT_SVH
`define IQ_FULLSCALE_PACKET_FRAMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, disabled in reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/iqfpf_pkg.sv
// ----------------------------------------------------------------------------
// iqfpf_pkg
// Types and constants shared by the packet framer and its sample scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package iqfpf_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int WORD_W      = 32;
    localparam int SCALE_W     = 16;
    localparam int FS_W        = 31;
    localparam int COUNT_W     = 16;
    localparam int SEQ_W       = 4;
    localparam int PICOS_W     = 40;
    localparam int CLASS_W     = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int WIX_W       = 3;

    // scaler datapath: N = 65534*mag + f, D = 2*f, q < 2^15
    localparam int QUO_W     = SCALE_W - 1;
    localparam int NUM_W     = FS_W + SCALE_W + 1;
    localparam int DEN_W     = FS_W + 1;
    localparam int REM_W     = NUM_W - QUO_W;
    localparam int TRIAL_W   = REM_W + 1;
    localparam int CMP_W     = (SAMPLE_BITS > FS_W) ? SAMPLE_BITS : FS_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    localparam logic [SCALE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SCALE_W-1:0] SAT_NEG = 16'h8000;
    localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'd65527;
    localparam logic [COUNT_W-1:0] HDR_WORDS   = 16'd8;
    localparam logic [FS_W-1:0]    FS_RESET    = 31'd32767;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_IDENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_IDENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 2'd2;

    localparam logic [WIX_W-1:0] WIX_HEADER   = 3'd0;
    localparam logic [WIX_W-1:0] WIX_STREAM   = 3'd1;
    localparam logic [WIX_W-1:0] WIX_CLASS_HI = 3'd2;
    localparam logic [WIX_W-1:0] WIX_CLASS_LO = 3'd3;
    localparam logic [WIX_W-1:0] WIX_SECONDS  = 3'd4;
    localparam logic [WIX_W-1:0] WIX_PICOS_HI = 3'd5;
    localparam logic [WIX_W-1:0] WIX_PICOS_LO = 3'd6;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_CMP,
        SC_ADD,
        SC_DIV,
        SC_NEG,
        SC_DONE
    } scl_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_WORDS,
        ST_SCALE_I,
        ST_SCALE_Q,
        ST_SAMPLE_WORD,
        ST_TRAILER
    } frm_state_t;

    typedef struct packed {
        logic               done;
        logic               clip;
        logic [SCALE_W-1:0] value;
    } scl_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/iqfpf_scaler.sv
// ----------------------------------------------------------------------------
// iqfpf_scaler
// Scales one component to 16 bits, round(v*32767/fs), halves away from
// zero, with saturation; radix-2 restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iqfpf_scaler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [iqfpf_pkg::SAMPLE_BITS-1:0]   raw,
    input  logic [iqfpf_pkg::FS_W-1:0]          full_scale,
    output iqfpf_pkg::scl_result_t              result
);

    iqfpf_pkg::scl_state_t state_reg, state_next;

    logic [iqfpf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                              neg_reg, neg_next;
    logic [iqfpf_pkg::SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic [iqfpf_pkg::FS_W-1:0]        f_reg, f_next;
    logic [iqfpf_pkg::NUM_W-1:0]       p_reg, p_next;
    logic [iqfpf_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [iqfpf_pkg::QUO_W-1:0]       quo_reg, quo_next;
    logic [iqfpf_pkg::SCALE_W-1:0]     value_reg, value_next;
    logic                              clip_reg, clip_next;

    logic [iqfpf_pkg::CMP_W-1:0]   mag_ext;
    logic [iqfpf_pkg::CMP_W-1:0]   f_ext;
    logic [iqfpf_pkg::NUM_W-1:0]   mag_num;
    logic [iqfpf_pkg::NUM_W-1:0]   num_sum;
    logic [iqfpf_pkg::TRIAL_W-1:0] trial;
    logic [iqfpf_pkg::TRIAL_W-1:0] den_ext;
    logic [iqfpf_pkg::TRIAL_W-1:0] diff;
    logic [iqfpf_pkg::SCALE_W-1:0] q16;

    assign mag_ext = iqfpf_pkg::CMP_W'(mag_reg);
    assign f_ext   = iqfpf_pkg::CMP_W'(f_reg);
    assign mag_num = iqfpf_pkg::NUM_W'(mag_ext);
    assign num_sum = p_reg + iqfpf_pkg::NUM_W'(f_reg);
    assign trial   = {rem_reg, quo_reg[iqfpf_pkg::QUO_W-1]};
    assign den_ext = iqfpf_pkg::TRIAL_W'({f_reg, 1'b0});
    assign diff    = trial - den_ext;
    assign q16     = {1'b0, quo_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iqfpf_pkg::SC_IDLE:
            begin
                if (start)
                begin
                    state_next = iqfpf_pkg::SC_CMP;
                end
            end
            iqfpf_pkg::SC_CMP:
            begin
                if (mag_ext >= f_ext)
                begin
                    state_next = iqfpf_pkg::SC_DONE;
                end
                else
                begin
                    state_next = iqfpf_pkg::SC_ADD;
                end
            end
            iqfpf_pkg::SC_ADD:
            begin
                state_next = iqfpf_pkg::SC_DIV;
            end
            iqfpf_pkg::SC_DIV:
            begin
                if (cnt_reg == iqfpf_pkg::DIV_LAST)
                begin
                    state_next = iqfpf_pkg::SC_NEG;
                end
            end
            iqfpf_pkg::SC_NEG:
            begin
                state_next = iqfpf_pkg::SC_DONE;
            end
            iqfpf_pkg::SC_DONE:
            begin
                state_next = iqfpf_pkg::SC_IDLE;
            end
            default:
            begin
                state_next = iqfpf_pkg::SC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        f_next     = f_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        value_next = value_reg;
        clip_next  = clip_reg;
        unique case (state_reg)
            iqfpf_pkg::SC_IDLE:
            begin
                if (start)
                begin
                    neg_next = raw[iqfpf_pkg::SAMPLE_BITS-1];
                    mag_next = raw[iqfpf_pkg::SAMPLE_BITS-1] ? ('0 - raw) : raw;
                    f_next   = (full_scale == '0) ? iqfpf_pkg::FS_W'(1) : full_scale;
                end
            end
            iqfpf_pkg::SC_CMP:
            begin
                clip_next  = mag_ext > f_ext;
                value_next = neg_reg ? iqfpf_pkg::SAT_NEG : iqfpf_pkg::SAT_POS;
                p_next     = (mag_num << iqfpf_pkg::SCALE_W) - (mag_num << 1);
            end
            iqfpf_pkg::SC_ADD:
            begin
                rem_next = num_sum[iqfpf_pkg::NUM_W-1:iqfpf_pkg::QUO_W];
                quo_next = num_sum[iqfpf_pkg::QUO_W-1:0];
                cnt_next = '0;
            end
            iqfpf_pkg::SC_DIV:
            begin
                if (trial >= den_ext)
                begin
                    rem_next = diff[iqfpf_pkg::REM_W-1:0];
                    quo_next = {quo_reg[iqfpf_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[iqfpf_pkg::REM_W-1:0];
                    quo_next = {quo_reg[iqfpf_pkg::QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            iqfpf_pkg::SC_NEG:
            begin
                value_next = neg_reg ? (iqfpf_pkg::SCALE_W'(0) - q16) : q16;
            end
            iqfpf_pkg::SC_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.done  = (state_reg == iqfpf_pkg::SC_DONE);
        result.clip  = clip_reg;
        result.value = value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iqfpf_pkg::SC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        f_reg     <= f_next;
        p_reg     <= p_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        value_reg <= value_next;
        clip_reg  <= clip_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/iq_fullscale_packet_framer_top.sv
// ----------------------------------------------------------------------------
// iq_fullscale_packet_framer_top
// Frames complex samples into signal data packets with stream id, class id,
// timestamps and trailer; samples are scaled to 16 bits against full scale.
//
//   channel  dir  handshake            beat
//   in       in   in_valid/in_ready    command, start fields, one I/Q sample
//   out      out  out_valid/out_ready  out_word, last_word, clip_total
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// Start beat: 7 output beats (8 for an empty packet), one per cycle when not stalled.
// Sample beat: the shared radix-2 divider scales I then Q (a saturated component
// skips the division) before the sample word, and the trailer after the last one.
// A new input beat is taken while the last output beat waits.
// Reset: no packet open, full scale 32767. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module iq_fullscale_packet_framer_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [iqfpf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [iqfpf_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      command,
    input  logic [iqfpf_pkg::SEQ_W-1:0]               packet_seq,
    input  logic [iqfpf_pkg::COUNT_W-1:0]             sample_total,
    input  logic [iqfpf_pkg::WORD_W-1:0]              seconds_stamp,
    input  logic [iqfpf_pkg::PICOS_W-1:0]             picos_stamp,
    input  logic                                      valid_flag,
    input  logic                                      caltime_flag,
    input  logic                                      reflock_flag,
    input  logic                                      loss_flag,
    input  logic signed [iqfpf_pkg::SAMPLE_BITS-1:0]  sample_i,
    input  logic signed [iqfpf_pkg::SAMPLE_BITS-1:0]  sample_q,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [iqfpf_pkg::WORD_W-1:0]              out_word,
    output logic                                      last_word,
    output logic [iqfpf_pkg::COUNT_W-1:0]             clip_total
);

`include "iq_fullscale_packet_framer_top_assert.svh"

    iqfpf_pkg::frm_state_t state_reg, state_next;

    logic [iqfpf_pkg::WORD_W-1:0]      stream_ident_reg, stream_ident_next;
    logic [iqfpf_pkg::CLASS_W-1:0]     class_ident_reg, class_ident_next;
    logic [iqfpf_pkg::FS_W-1:0]        full_scale_reg, full_scale_next;

    logic [iqfpf_pkg::COUNT_W-1:0]     remaining_reg, remaining_next;
    logic [iqfpf_pkg::COUNT_W-1:0]     clip_count_reg, clip_count_next;
    logic                              active_reg, active_next;
    logic [3:0]                        held_flags_reg, held_flags_next;
    logic [iqfpf_pkg::WIX_W-1:0]       idx_reg, idx_next;
    logic                              kick_reg, kick_next;
    logic                              clip_any_reg, clip_any_next;

    logic [iqfpf_pkg::SEQ_W-1:0]       seq_reg, seq_next;
    logic [iqfpf_pkg::WORD_W-1:0]      seconds_reg, seconds_next;
    logic [iqfpf_pkg::PICOS_W-1:0]     picos_reg, picos_next;
    logic [iqfpf_pkg::SAMPLE_BITS-1:0] sample_i_reg, sample_i_next;
    logic [iqfpf_pkg::SAMPLE_BITS-1:0] sample_q_reg, sample_q_next;
    logic [iqfpf_pkg::SCALE_W-1:0]     i_val_reg, i_val_next;
    logic [iqfpf_pkg::SCALE_W-1:0]     q_val_reg, q_val_next;

    logic                              out_valid_reg, out_valid_next;
    logic [iqfpf_pkg::WORD_W-1:0]      out_word_reg, out_word_next;
    logic                              last_word_reg, last_word_next;
    logic [iqfpf_pkg::COUNT_W-1:0]     clip_total_reg, clip_total_next;

    logic                              accept;
    logic                              load;
    logic                              start_accept;
    logic                              in_scale;
    logic [iqfpf_pkg::COUNT_W-1:0]     count_clamped;
    logic [iqfpf_pkg::WORD_W-1:0]      header_word;
    logic [iqfpf_pkg::WORD_W-1:0]      trailer_word;
    logic [iqfpf_pkg::WORD_W-1:0]      start_word;
    logic [iqfpf_pkg::SAMPLE_BITS-1:0] scl_raw;
    iqfpf_pkg::scl_result_t            scl_res;

    assign in_ready   = (state_reg == iqfpf_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign load       = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_word   = out_word_reg;
    assign last_word  = last_word_reg;
    assign clip_total = clip_total_reg;

    assign start_accept = accept && (command == iqfpf_pkg::CMD_START);
    assign in_scale     = (state_reg == iqfpf_pkg::ST_SCALE_I) ||
                          (state_reg == iqfpf_pkg::ST_SCALE_Q);

    assign count_clamped = (sample_total > iqfpf_pkg::MAX_SAMPLES) ?
                           iqfpf_pkg::MAX_SAMPLES : sample_total;

    // type 1, class id and trailer present, UTC, picoseconds
    assign header_word = {4'd1, 1'b1, 1'b1, 2'b00, 2'b01, 2'b10, seq_reg,
                          remaining_reg + iqfpf_pkg::HDR_WORDS};

    // enables: caltime, valid, reflock, over-range, loss
    assign trailer_word = {3'b111, 3'b000, 2'b11, 4'b0000,
                           held_flags_reg[1], held_flags_reg[0], held_flags_reg[2],
                           3'b000, (clip_count_reg != '0), held_flags_reg[3], 12'd0};

    assign scl_raw = (state_reg == iqfpf_pkg::ST_SCALE_Q) ? sample_q_reg : sample_i_reg;

    always_comb
    begin
        unique case (idx_reg)
            iqfpf_pkg::WIX_HEADER:   start_word = header_word;
            iqfpf_pkg::WIX_STREAM:   start_word = stream_ident_reg;
            iqfpf_pkg::WIX_CLASS_HI: start_word = class_ident_reg[63:32];
            iqfpf_pkg::WIX_CLASS_LO: start_word = class_ident_reg[31:0];
            iqfpf_pkg::WIX_SECONDS:  start_word = seconds_reg;
            iqfpf_pkg::WIX_PICOS_HI: start_word = iqfpf_pkg::WORD_W'(picos_reg[39:32]);
            iqfpf_pkg::WIX_PICOS_LO: start_word = picos_reg[31:0];
            default:                 start_word = '0;
        endcase
    end

    iqfpf_scaler u_scaler (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (kick_reg),
        .raw        (scl_raw),
        .full_scale (full_scale_reg),
        .result     (scl_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iqfpf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == iqfpf_pkg::CMD_START)
                    begin
                        state_next = iqfpf_pkg::ST_START_WORDS;
                    end
                    else if (active_reg)
                    begin
                        state_next = iqfpf_pkg::ST_SCALE_I;
                    end
                end
            end
            iqfpf_pkg::ST_START_WORDS:
            begin
                if (load && (idx_reg == iqfpf_pkg::WIX_PICOS_LO))
                begin
                    if (remaining_reg == '0)
                    begin
                        state_next = iqfpf_pkg::ST_TRAILER;
                    end
                    else
                    begin
                        state_next = iqfpf_pkg::ST_IDLE;
                    end
                end
            end
            iqfpf_pkg::ST_SCALE_I:
            begin
                if (scl_res.done)
                begin
                    state_next = iqfpf_pkg::ST_SCALE_Q;
                end
            end
            iqfpf_pkg::ST_SCALE_Q:
            begin
                if (scl_res.done)
                begin
                    state_next = iqfpf_pkg::ST_SAMPLE_WORD;
                end
            end
            iqfpf_pkg::ST_SAMPLE_WORD:
            begin
                if (load)
                begin
                    if (remaining_reg == iqfpf_pkg::COUNT_W'(1))
                    begin
                        state_next = iqfpf_pkg::ST_TRAILER;
                    end
                    else
                    begin
                        state_next = iqfpf_pkg::ST_IDLE;
                    end
                end
            end
            iqfpf_pkg::ST_TRAILER:
            begin
                if (load)
                begin
                    state_next = iqfpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iqfpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stream_ident_next = stream_ident_reg;
        class_ident_next  = class_ident_reg;
        full_scale_next   = full_scale_reg;
        remaining_next    = remaining_reg;
        clip_count_next   = clip_count_reg;
        active_next       = active_reg;
        held_flags_next   = held_flags_reg;
        idx_next          = idx_reg;
        kick_next         = 1'b0;
        clip_any_next     = clip_any_reg;
        seq_next          = seq_reg;
        seconds_next      = seconds_reg;
        picos_next        = picos_reg;
        sample_i_next     = sample_i_reg;
        sample_q_next     = sample_q_reg;
        i_val_next        = i_val_reg;
        q_val_next        = q_val_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_word_next     = out_word_reg;
        last_word_next    = last_word_reg;
        clip_total_next   = clip_total_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                iqfpf_pkg::CFG_STREAM_IDENT: stream_ident_next = cfg_data[31:0];
                iqfpf_pkg::CFG_CLASS_IDENT:  class_ident_next  = cfg_data;
                iqfpf_pkg::CFG_FULL_SCALE:   full_scale_next   = cfg_data[30:0];
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            iqfpf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    sample_i_next = sample_i;
                    sample_q_next = sample_q;
                    if (command == iqfpf_pkg::CMD_START)
                    begin
                        seq_next        = packet_seq;
                        seconds_next    = seconds_stamp;
                        picos_next      = picos_stamp;
                        remaining_next  = count_clamped;
                        clip_count_next = '0;
                        held_flags_next = {loss_flag, reflock_flag, caltime_flag, valid_flag};
                        active_next     = (count_clamped != '0);
                        idx_next        = iqfpf_pkg::WIX_HEADER;
                    end
                    else if (active_reg)
                    begin
                        kick_next = 1'b1;
                    end
                end
            end
            iqfpf_pkg::ST_START_WORDS:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = start_word;
                    last_word_next  = 1'b0;
                    clip_total_next = clip_count_reg;
                    idx_next        = idx_reg + 1'b1;
                end
            end
            iqfpf_pkg::ST_SCALE_I:
            begin
                if (scl_res.done)
                begin
                    i_val_next    = scl_res.value;
                    clip_any_next = scl_res.clip;
                    kick_next     = 1'b1;
                end
            end
            iqfpf_pkg::ST_SCALE_Q:
            begin
                if (scl_res.done)
                begin
                    q_val_next = scl_res.value;
                    if ((clip_any_reg || scl_res.clip) && (clip_count_reg != '1))
                    begin
                        clip_count_next = clip_count_reg + 1'b1;
                    end
                end
            end
            iqfpf_pkg::ST_SAMPLE_WORD:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = {i_val_reg, q_val_reg};
                    last_word_next  = 1'b0;
                    clip_total_next = clip_count_reg;
                    remaining_next  = remaining_reg - 1'b1;
                    if (remaining_reg == iqfpf_pkg::COUNT_W'(1))
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            iqfpf_pkg::ST_TRAILER:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = trailer_word;
                    last_word_next  = 1'b1;
                    clip_total_next = clip_count_reg;
                    active_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= iqfpf_pkg::ST_IDLE;
            stream_ident_reg <= '0;
            class_ident_reg  <= '0;
            full_scale_reg   <= iqfpf_pkg::FS_RESET;
            remaining_reg    <= '0;
            clip_count_reg   <= '0;
            active_reg       <= 1'b0;
            held_flags_reg   <= '0;
            idx_reg          <= '0;
            kick_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stream_ident_reg <= stream_ident_next;
            class_ident_reg  <= class_ident_next;
            full_scale_reg   <= full_scale_next;
            remaining_reg    <= remaining_next;
            clip_count_reg   <= clip_count_next;
            active_reg       <= active_next;
            held_flags_reg   <= held_flags_next;
            idx_reg          <= idx_next;
            kick_reg         <= kick_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clip_any_reg   <= clip_any_next;
        seq_reg        <= seq_next;
        seconds_reg    <= seconds_next;
        picos_reg      <= picos_next;
        sample_i_reg   <= sample_i_next;
        sample_q_reg   <= sample_q_next;
        i_val_reg      <= i_val_next;
        q_val_reg      <= q_val_next;
        out_word_reg   <= out_word_next;
        last_word_reg  <= last_word_next;
        clip_total_reg <= clip_total_next;
    end

    // an open packet always has samples left
    `ASSERT_IMPLIES(a_active_remaining, active_reg, remaining_reg != '0)
    `ASSERT_NEXT(a_start_clears_clip, start_accept, clip_count_reg == '0)
    `ASSERT_IMPLIES(a_kick_in_scale, kick_reg, in_scale)
    `ASSERT_IMPLIES(a_done_in_scale, scl_res.done, in_scale)

endmodule

`default_nettype wire
